// ----- src/lzfsd_pkg.sv -----
package lzfsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 24;
    localparam int DIST_W   = 12;
    localparam int LEN_W    = 5;
    localparam int TOK_W    = 4;
    localparam int HDR_W    = 2;
    localparam int MIN_LEN  = 3;
    localparam int FLAG_CNT = 8;
    localparam logic [HDR_W-1:0] HDR_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_FLAG,
        ST_TOKEN,
        ST_REFLOW,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic start;
        logic hdr_load;
        logic flag_load;
        logic ref_hi_load;
        logic lit_emit;
        logic copy_start;
        logic copy_emit;
        logic copy_read;
        logic adv_token;
    } cmd_t;

    typedef struct packed {
        logic flag_top;
        logic tokens_last;
        logic hdr_last;
        logic size_zero;
        logic fin;
        logic len_last;
        logic out_free;
    } status_t;

endpackage

// ----- src/lzfsd_ram.sv -----
module lzfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/lzfsd_ctrl.sv -----
module lzfsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               stream_start,
    input  lzfsd_pkg::status_t status,
    output logic               in_ready,
    output lzfsd_pkg::cmd_t    cmd,
    output lzfsd_pkg::state_t  state
);

    import lzfsd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   data_acc;

    assign state    = state_reg;
    assign in_ready = (state_reg != ST_COPY) && ((state_reg != ST_TOKEN) || status.out_free);
    assign accept   = in_valid && in_ready;
    assign data_acc = accept && !stream_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept && stream_start)
        begin
            state_next = ST_HEADER;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    state_next = ST_IDLE;
                end
                ST_HEADER:
                begin
                    if (data_acc && status.hdr_last)
                    begin
                        state_next = status.size_zero ? ST_IDLE : ST_FLAG;
                    end
                end
                ST_FLAG:
                begin
                    if (data_acc)
                    begin
                        state_next = ST_TOKEN;
                    end
                end
                ST_TOKEN:
                begin
                    if (data_acc)
                    begin
                        if (status.flag_top)
                        begin
                            state_next = ST_REFLOW;
                        end
                        else if (status.fin)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = status.tokens_last ? ST_FLAG : ST_TOKEN;
                        end
                    end
                end
                ST_REFLOW:
                begin
                    if (data_acc)
                    begin
                        state_next = ST_COPY;
                    end
                end
                ST_COPY:
                begin
                    if (status.out_free)
                    begin
                        if (status.fin)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (status.len_last)
                        begin
                            state_next = status.tokens_last ? ST_FLAG : ST_TOKEN;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.start       = accept && stream_start;
        cmd.hdr_load    = data_acc && (state_reg == ST_HEADER);
        cmd.flag_load   = data_acc && (state_reg == ST_FLAG);
        cmd.ref_hi_load = data_acc && (state_reg == ST_TOKEN) && status.flag_top;
        cmd.lit_emit    = data_acc && (state_reg == ST_TOKEN) && !status.flag_top;
        cmd.copy_start  = data_acc && (state_reg == ST_REFLOW);
        cmd.copy_emit   = (state_reg == ST_COPY) && status.out_free;
        cmd.copy_read   = cmd.copy_emit && !status.fin && !status.len_last;
        cmd.adv_token   = (cmd.lit_emit && !status.fin)
                       || (cmd.copy_emit && !status.fin && status.len_last);
    end

endmodule

// ----- src/lzfsd_dpath.sv -----
module lzfsd_dpath #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lzfsd_pkg::BYTE_W-1:0]     in_byte,
    input  lzfsd_pkg::cmd_t                  cmd,
    input  logic                             out_ready,
    output lzfsd_pkg::status_t               status,
    output logic                             out_valid,
    output logic [lzfsd_pkg::BYTE_W-1:0]     out_byte,
    output logic                             last
);

    import lzfsd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [AW-1:0]     wp_reg,        wp_next;
    logic              full_reg,      full_next;
    logic [SIZE_W-1:0] remain_reg,    remain_next;
    logic [BYTE_W-1:0] flag_reg,      flag_next;
    logic [TOK_W-1:0]  tokens_reg,    tokens_next;
    logic [HDR_W-1:0]  hdr_cnt_reg,   hdr_cnt_next;
    logic [BYTE_W-1:0] ref_hi_reg,    ref_hi_next;
    logic [AW-1:0]     src_reg,       src_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic              bypass_reg,    bypass_next;
    logic [BYTE_W-1:0] byp_data_reg,  byp_data_next;
    logic              rd_valid_reg,  rd_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg,  out_byte_next;
    logic              last_reg,      last_next;

    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic [BYTE_W-1:0] rd_byte;
    logic [BYTE_W-1:0] ram_q;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [DIST_W:0]   ref_dist;

    assign emit      = cmd.lit_emit || cmd.copy_emit;
    assign rd_byte   = bypass_reg ? byp_data_reg : (rd_valid_reg ? ram_q : '0);
    assign emit_byte = cmd.lit_emit ? in_byte : rd_byte;
    assign ref_dist  = {1'b0, ref_hi_reg[3:0], in_byte} + (DIST_W+1)'(1);
    assign re        = cmd.copy_start || cmd.copy_read;
    assign raddr     = cmd.copy_start ? AW'(wp_reg - AW'(ref_dist)) : AW'(src_reg + AW'(1));

    lzfsd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (emit),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        status.flag_top    = flag_reg[BYTE_W-1];
        status.tokens_last = (tokens_reg == TOK_W'(1));
        status.hdr_last    = (hdr_cnt_reg == HDR_LAST);
        status.size_zero   = (in_byte == '0) && (remain_reg[15:0] == '0);
        status.fin         = (remain_reg == SIZE_W'(1));
        status.len_last    = (len_reg == LEN_W'(1));
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        wp_next        = wp_reg;
        full_next      = full_reg;
        remain_next    = remain_reg;
        flag_next      = flag_reg;
        tokens_next    = tokens_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        ref_hi_next    = ref_hi_reg;
        src_next       = src_reg;
        len_next       = len_reg;
        bypass_next    = bypass_reg;
        byp_data_next  = byp_data_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;

        if (cmd.start)
        begin
            remain_next  = '0;
            flag_next    = '0;
            tokens_next  = '0;
            ref_hi_next  = '0;
            hdr_cnt_next = HDR_W'(1);
        end

        if (cmd.hdr_load)
        begin
            case (hdr_cnt_reg)
                2'd1:    remain_next[7:0]   = in_byte;
                2'd2:    remain_next[15:8]  = in_byte;
                2'd3:    remain_next[23:16] = in_byte;
                default: remain_next        = remain_reg;
            endcase
            hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
        end

        if (cmd.flag_load)
        begin
            flag_next   = in_byte;
            tokens_next = TOK_W'(FLAG_CNT);
        end

        if (cmd.ref_hi_load)
        begin
            ref_hi_next = in_byte;
        end

        if (cmd.copy_start)
        begin
            len_next = LEN_W'(ref_hi_reg[7:4]) + LEN_W'(MIN_LEN);
        end
        else if (cmd.copy_emit)
        begin
            len_next = len_reg - LEN_W'(1);
        end

        if (re)
        begin
            src_next      = raddr;
            bypass_next   = emit && (raddr == wp_reg);
            byp_data_next = emit_byte;
            rd_valid_next = full_reg || (raddr < wp_reg);
        end

        if (emit)
        begin
            wp_next        = wp_reg + AW'(1);
            if (wp_reg == AW'(WINDOW_DEPTH - 1))
            begin
                full_next = 1'b1;
            end
            remain_next    = remain_reg - SIZE_W'(1);
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            last_next      = status.fin;
        end

        if (cmd.adv_token)
        begin
            flag_next   = {flag_reg[BYTE_W-2:0], 1'b0};
            tokens_next = tokens_reg - TOK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            remain_reg    <= '0;
            flag_reg      <= '0;
            tokens_reg    <= '0;
            hdr_cnt_reg   <= '0;
            ref_hi_reg    <= '0;
            len_reg       <= '0;
            bypass_reg    <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            full_reg      <= full_next;
            remain_reg    <= remain_next;
            flag_reg      <= flag_next;
            tokens_reg    <= tokens_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            ref_hi_reg    <= ref_hi_next;
            len_reg       <= len_next;
            bypass_reg    <= bypass_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        byp_data_reg <= byp_data_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

// ----- src/lz77_flag_stream_decompressor_unit.sv -----
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_byte[7:0], stream_start
// out      out_valid / out_ready out_byte[7:0], last
//
// Header, flag and first reference bytes only update registers; a literal byte is written to the window and output.
// The second reference byte starts a copy of 3 to 18 bytes: one window read per cycle while the output is free,
// with a bypass for a read of the byte written in the same cycle.
// Reset clears control state only; a fill pointer marks unwritten window entries as zero.
// A full output register stalls token bytes and copies; input is held off during a copy.
module lz77_flag_stream_decompressor_unit #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lzfsd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          stream_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lzfsd_pkg::BYTE_W-1:0]  out_byte,
    output logic                          last
);

    import lzfsd_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    lzfsd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .stream_start (stream_start),
        .status       (status),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .state        (state)
    );

    lzfsd_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .cmd       (cmd),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last)
    );

    a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_COPY) |-> !in_ready)
        else $error("input accepted during copy");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lit_emit || cmd.copy_emit) |-> status.out_free)
        else $error("emit over pending output");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.copy_emit && status.fin) |=> (state == ST_IDLE) && out_valid && last)
        else $error("final copy byte did not end stream");

endmodule

// ----- tb/lzfsd_stream_checker.sv -----
module lzfsd_stream_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [lzfsd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          stream_start,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lzfsd_pkg::BYTE_W-1:0]  out_byte,
    input  logic                          last,
    output int                            failures,
    output int                            outstanding
);

    import lzfsd_pkg::*;

    localparam int WIN_SIZE = 1 << DIST_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_item_t;

    out_item_t         expected_out [$];

    logic [BYTE_W-1:0] hist_mem [WIN_SIZE];
    logic [DIST_W-1:0] wr_ptr;
    logic [SIZE_W-1:0] left_count;
    logic [BYTE_W-1:0] flag_reg;
    logic [TOK_W-1:0]  tok_count;
    logic [HDR_W-1:0]  hdr_idx;
    logic [BYTE_W-1:0] ref_hi;
    state_t            phase;

    function automatic logic emit_byte(input logic [BYTE_W-1:0] b);
        out_item_t it;
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + DIST_W'(1);
        left_count = left_count - SIZE_W'(1);
        it.data = b;
        it.last = (left_count == '0);
        expected_out.push_back(it);
        if (it.last)
            phase = ST_IDLE;
        return it.last;
    endfunction

    function automatic void advance_token();
        flag_reg = flag_reg << 1;
        tok_count = tok_count - TOK_W'(1);
        phase = (tok_count == '0) ? ST_FLAG : ST_TOKEN;
    endfunction

    function automatic void decode_item(input logic [BYTE_W-1:0] b, input logic s);
        logic [DIST_W-1:0] src;
        int                len;
        int                sh;
        logic              fin;
        if (s) begin
            phase = ST_HEADER;
            hdr_idx = HDR_W'(1);
            left_count = '0;
            flag_reg = '0;
            tok_count = '0;
            ref_hi = '0;
            return;
        end
        case (phase)
            ST_HEADER: begin
                sh = 8 * (int'(hdr_idx) - 1);
                left_count = left_count | (SIZE_W'(b) << sh);
                if (hdr_idx == HDR_LAST)
                    phase = (left_count == '0) ? ST_IDLE : ST_FLAG;
                hdr_idx = hdr_idx + HDR_W'(1);
            end
            ST_FLAG: begin
                flag_reg = b;
                tok_count = TOK_W'(FLAG_CNT);
                phase = ST_TOKEN;
            end
            ST_TOKEN: begin
                if (flag_reg[BYTE_W-1]) begin
                    ref_hi = b;
                    phase = ST_REFLOW;
                end else if (!emit_byte(b)) begin
                    advance_token();
                end
            end
            ST_REFLOW: begin
                len = int'(ref_hi[7:4]) + MIN_LEN;
                src = wr_ptr - {ref_hi[3:0], b} - DIST_W'(1);
                fin = 1'b0;
                for (int k = 0; k < len && !fin; k++) begin
                    fin = emit_byte(hist_mem[src]);
                    src = src + DIST_W'(1);
                end
                if (!fin)
                    advance_token();
            end
            default: phase = ST_IDLE;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t exp_item;
        if (!rst_n) begin
            for (int i = 0; i < WIN_SIZE; i++)
                hist_mem[i] = '0;
            wr_ptr = '0;
            left_count = '0;
            flag_reg = '0;
            tok_count = '0;
            hdr_idx = '0;
            ref_hi = '0;
            phase = ST_IDLE;
            expected_out.delete();
            failures = 0;
            outstanding = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected item out_byte %02h last %0b",
                             $time, out_byte, last);
                    failures = failures + 1;
                end else begin
                    exp_item = expected_out.pop_front();
                    if (out_byte !== exp_item.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, exp_item.data, out_byte);
                        failures = failures + 1;
                    end
                    if (last !== exp_item.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_item.last, last);
                        failures = failures + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                decode_item(in_byte, stream_start);
            outstanding = expected_out.size();
        end
    end

endmodule

// ----- tb/lz77_flag_stream_decompressor_unit_test.sv -----
module lz77_flag_stream_decompressor_unit_test;

    import lzfsd_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 75;
    localparam int TAIL_CYCLES  = 40;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              stream_start = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    int                failures;
    int                outstanding;

    logic [BYTE_W:0]   stim_q [$];   // {stream_start, in_byte}
    int                stall_left = 0;
    logic              out_burst = 1'b0;
    int                idle_cycles;

    lz77_flag_stream_decompressor_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last         (last)
    );

    lzfsd_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last         (last),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0)
            out_burst <= !out_burst;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!out_burst && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic push_item(input logic s, input logic [BYTE_W-1:0] b);
        stim_q.push_back({s, b});
    endtask

    // kind: 0 well formed, 1 truncated, 2 huge size cut short, 3 trailing bytes
    task automatic add_stream(input int kind);
        int                size;
        int                made;
        int                cut;
        int                len;
        int                back;
        int                r;
        logic [BYTE_W-1:0] flags;
        r = $urandom_range(0, 19);
        if (r == 0)
            size = 0;
        else if (r == 1)
            size = $urandom_range(100, 300);
        else
            size = $urandom_range(1, 40);
        if (kind == 2)
            size = $urandom_range(1 << 16, (1 << SIZE_W) - 1);
        push_item(1'b1, BYTE_W'($urandom));
        push_item(1'b0, size[7:0]);
        push_item(1'b0, size[15:8]);
        push_item(1'b0, size[23:16]);
        made = 0;
        cut = size;
        if (kind == 1 && size > 0)
            cut = $urandom_range(1, size);
        if (kind == 2)
            cut = $urandom_range(5, 30);
        while (made < size && made < cut) begin
            flags = BYTE_W'($urandom);
            push_item(1'b0, flags);
            for (int i = BYTE_W - 1; i >= 0 && made < size && made < cut; i--) begin
                if (flags[i]) begin
                    len = $urandom_range(0, 15);
                    if ($urandom_range(0, 3) != 0)
                        back = $urandom_range(0, 15);
                    else
                        back = $urandom_range(0, (1 << DIST_W) - 1);
                    push_item(1'b0, {len[3:0], back[11:8]});
                    push_item(1'b0, back[7:0]);
                    made = made + len + MIN_LEN;
                end else begin
                    push_item(1'b0, BYTE_W'($urandom));
                    made = made + 1;
                end
            end
        end
        if (kind == 1 && $urandom_range(0, 1) == 0)
            push_item(1'b0, BYTE_W'($urandom));
        if (kind == 3) begin
            r = $urandom_range(1, 3);
            repeat (r) push_item(1'b0, BYTE_W'($urandom));
        end
    endtask

    task automatic send_item(input logic [BYTE_W:0] item, input logic burst);
        int gap;
        gap = 0;
        if (!burst && $urandom_range(0, 1) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_start <= item[BYTE_W];
        in_byte <= item[BYTE_W-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int   r;
        int   directed_len;
        logic burst;

        // idle bytes, nothing comes out
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        // literal, overlapping max length run, literal, far reference cut by size
        push_item(1'b1, 8'h10);
        push_item(1'b0, 8'h15);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h50);
        push_item(1'b0, 8'hA5);
        push_item(1'b0, 8'hF0);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h5A);
        push_item(1'b0, 8'h3F);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h77);
        // zero size, then a stray byte
        push_item(1'b1, 8'h10);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h33);
        // max size, all references, restarted mid stream
        push_item(1'b1, 8'h10);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h01);
        directed_len = stim_q.size();

        while (stim_q.size() < directed_len + RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                add_stream(0);
            else
                add_stream(r - 6);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst = 1'b0;
        while (stim_q.size() != 0) begin
            if ($urandom_range(0, 15) == 0)
                burst = !burst;
            send_item(stim_q.pop_front(), burst);
        end
        in_valid <= 1'b0;
        stream_start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (outstanding != 0)
                $display("%0t: %0d expected items never arrived", $time, outstanding);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
